// ===== rtl/bubble_sort_early_exit_top_assert.svh =====
// Assertion macros for the top-level RTL file of the sorter.
// Each macro takes a label, the clock, the active-low reset and two expressions.
`ifndef BUBBLE_SORT_EARLY_EXIT_TOP_ASSERT_SVH
`define BUBBLE_SORT_EARLY_EXIT_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define BSE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bse assertion failed");

// Next-cycle implication.
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bse assertion failed");

`else

`define BSE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BSE_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/bse_pkg.sv =====
`timescale 1ns / 1ps

package bse_pkg;

  localparam int VALUE_W = 32;

  typedef enum logic {
    ST_COLLECT,
    ST_EMIT
  } state_t;

  // Control broadcast to every cell of the chain.
  typedef struct packed {
    logic                       insert;
    logic                       shift;
    logic signed [VALUE_W-1:0]  value;
  } cell_ctl_t;

endpackage

// ===== rtl/bse_cell.sv =====
`timescale 1ns / 1ps

module bse_cell
  import bse_pkg::*;
(
  input  logic                      clk,
  input  cell_ctl_t                 ctl,
  input  logic                      valid_i,
  input  logic signed [VALUE_W-1:0] prev_val_i,
  input  logic                      prev_gt_i,
  input  logic signed [VALUE_W-1:0] next_val_i,
  output logic signed [VALUE_W-1:0] value_o,
  output logic                      gt_o
);

  logic signed [VALUE_W-1:0] val_r, val_nxt;

  // An empty cell counts as larger than anything, so new values land at the tail.
  assign gt_o    = !valid_i || (val_r > ctl.value);
  assign value_o = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.shift) begin
      val_nxt = next_val_i;
    end else if (ctl.insert && gt_o) begin
      // take the neighbor's value if it also moves up, else the new value
      val_nxt = prev_gt_i ? prev_val_i : ctl.value;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

// ===== rtl/bubble_sort_early_exit_top.sv =====
`timescale 1ns / 1ps
// Channel | Dir | tdata                    | tlast       | tuser
// in_     | in  | [31:0] value (signed)    | final_req   | -
// out_    | out | [31:0] sorted_value      | end_of_run  | [0] overflow
//
// Each element accepted while there is room is placed into sorted position by the chain of
// cells (one signed compare per cell against the incoming value, shift of the tail).
// After the final element, the set drains from cell 0 at one result per cycle while out_tready
// is high; in_tready stays low while draining. Reset clears the fill count, the overflow
// flag and the state; cell contents are not reset and are only read once written. A stalled
// out_tready holds the chain.
`include "bubble_sort_early_exit_top_assert.svh"

module bubble_sort_early_exit_top
  import bse_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] sorted_value
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // [0] overflow
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               drop_r, drop_nxt;
  logic               in_acc, out_acc, full;
  cell_ctl_t          ctl;

  logic signed [VALUE_W-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]          cell_gt;
  logic [DEPTH-1:0]          cell_valid;

  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;
  assign full    = (count_r == CNT_W'(DEPTH));

  // Insert only while there is room; a transaction on a full store is dropped.
  assign ctl.insert = in_acc & ~full;
  assign ctl.shift  = out_acc;
  assign ctl.value  = $signed(in_tdata);

  // Chain of cells: cell 0 holds the smallest value.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_val, next_val;
    logic                      prev_gt;

    assign cell_valid[i] = (count_r > CNT_W'(i));

    if (i == 0) begin : g_head
      assign prev_val = ctl.value;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_val = cell_val[i];
    end else begin : g_mid
      assign next_val = cell_val[i+1];
    end

    bse_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .valid_i    (cell_valid[i]),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .next_val_i (next_val),
      .value_o    (cell_val[i]),
      .gt_o       (cell_gt[i])
    );
  end

  // Next state: collect until the final element, then drain the chain.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc && in_tlast) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && (count_r == CNT_W'(1))) begin
          state_nxt = ST_COLLECT;
        end
      end
      default: state_nxt = ST_COLLECT;
    endcase
  end

  // Fill count and overflow flag; the count doubles as the number left to emit.
  always_comb begin
    count_nxt = count_r;
    drop_nxt  = drop_r;
    unique case (state_r)
      ST_COLLECT: begin
        if (in_acc) begin
          if (full) begin
            drop_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ST_EMIT: begin
        if (out_acc) begin
          count_nxt = count_r - CNT_W'(1);
          if (count_r == CNT_W'(1)) begin
            drop_nxt = 1'b0;
          end
        end
      end
      default: begin
        count_nxt = '0;
        drop_nxt  = 1'b0;
      end
    endcase
  end

  // Outputs: the head cell is the output register.
  always_comb begin
    in_tready    = (state_r == ST_COLLECT);
    out_tvalid   = (state_r == ST_EMIT);
    out_tdata    = cell_val[0];
    out_tlast    = (count_r == CNT_W'(1));
    out_tuser[0] = drop_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_COLLECT;
      count_r <= '0;
      drop_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      drop_r  <= drop_nxt;
    end
  end

  // Never emit from an empty chain.
  `BSE_ASSERT_IMP(a_emit_nonempty, clk, rst_n, out_tvalid, count_r != '0)
  // The fill count never passes the store depth.
  `BSE_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_r <= CNT_W'(DEPTH))
  // The final element starts draining in the next cycle.
  `BSE_ASSERT_NEXT(a_final_drains, clk, rst_n, in_acc && in_tlast, out_tvalid)
  // The two head cells are in ascending order while draining.
  `BSE_ASSERT_IMP(a_head_sorted, clk, rst_n, out_tvalid && (count_r > CNT_W'(1)), cell_val[0] <= cell_val[1])
  // After the last result the block takes input again.
  `BSE_ASSERT_NEXT(a_last_reopens, clk, rst_n, out_acc && out_tlast, in_tready && !drop_r)

endmodule

// ===== sim/bubble_sort_early_exit_top_test.sv =====
`timescale 1ns / 1ps

typedef struct packed {
  logic signed [bse_pkg::VALUE_W-1:0] sorted_value;
  logic                               end_of_run;
  logic                               overflow;
} sorted_entry_t;

// Holds the current set as it arrives and, on the final element, queues the
// ascending order of what was kept in the store.
class sort_scoreboard;
  int unsigned                        depth;
  logic signed [bse_pkg::VALUE_W-1:0] held[$];
  bit                                 dropped;
  sorted_entry_t                      awaiting[$];
  int unsigned                        errors;

  function new(int unsigned store_depth);
    depth   = store_depth;
    dropped = 1'b0;
    errors  = 0;
  endfunction

  function void note_input(logic signed [bse_pkg::VALUE_W-1:0] value, logic last);
    logic signed [bse_pkg::VALUE_W-1:0] run[$];
    logic signed [bse_pkg::VALUE_W-1:0] tmp;
    sorted_entry_t                      entry;
    bit                                 swapped;
    if (held.size() < depth) begin
      held.push_back(value);
    end else begin
      dropped = 1'b1;
    end
    if (!last) return;
    run = held;
    // bubble passes over a shrinking range, stop after a pass with no swap
    for (int lim = run.size() - 1; lim > 0; lim--) begin
      swapped = 1'b0;
      for (int j = 0; j < lim; j++) begin
        if (run[j] > run[j+1]) begin
          tmp      = run[j];
          run[j]   = run[j+1];
          run[j+1] = tmp;
          swapped  = 1'b1;
        end
      end
      if (!swapped) break;
    end
    foreach (run[k]) begin
      entry.sorted_value = run[k];
      entry.end_of_run   = (k == run.size() - 1);
      entry.overflow     = dropped;
      awaiting.push_back(entry);
    end
    held.delete();
    dropped = 1'b0;
  endfunction

  function void check_result(logic [31:0] data, logic last, logic ovf);
    sorted_entry_t exp_entry;
    if (awaiting.size() == 0) begin
      $error("unexpected result: sorted_value %0d", $signed(data));
      errors++;
      return;
    end
    exp_entry = awaiting.pop_front();
    if (data !== exp_entry.sorted_value) begin
      $error("sorted_value: expected %0d, got %0d", exp_entry.sorted_value, $signed(data));
      errors++;
    end
    if (last !== exp_entry.end_of_run) begin
      $error("end_of_run: expected %0d, got %0d", exp_entry.end_of_run, last);
      errors++;
    end
    if (ovf !== exp_entry.overflow) begin
      $error("overflow: expected %0d, got %0d", exp_entry.overflow, ovf);
      errors++;
    end
  endfunction

  function int unsigned pending();
    return awaiting.size();
  endfunction
endclass

module bubble_sort_early_exit_top_test;
  import bse_pkg::*;

  localparam int          DEPTH       = 32;
  localparam int          RANDOM_ITEMS = 300;
  localparam int          QUIET_AFTER  = 250;
  localparam logic [31:0] VAL_MAX     = 32'h7FFF_FFFF;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [31:0] value
  logic        in_tlast;   // final_req
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] sorted_value
  logic        out_tlast;  // end_of_run
  logic [0:0]  out_tuser;  // [0] overflow

  sort_scoreboard sb;
  int unsigned    items_sent;
  bit             quiet;     // no idling on either side in the last part of the run
  bit             calm_set;  // no sender gaps for the current set
  int unsigned    stall_left;
  int unsigned    calm_left;

  bubble_sort_early_exit_top #(.DEPTH(DEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Hard stop: far beyond the slowest legal run (every gap and stall at its longest).
  initial begin
    #5ms;
    $display("bubble_sort_early_exit_top_test: FAIL");
    $finish;
  end

  // Result side: check each accepted transaction against the oldest expectation,
  // then decide the ready level for the next edge. Random stall bursts, with occasional
  // long calm stretches, and no new burst once the run goes quiet.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
      calm_left  <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        sb.check_result(out_tdata, out_tlast, out_tuser[0]);
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left  <= calm_left - 1;
        out_tready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left <= $urandom_range(1, 17) - 1;
        out_tready <= 1'b0;
      end else begin
        if ($urandom_range(0, 39) == 0) calm_left <= $urandom_range(30, 80);
        out_tready <= 1'b1;
      end
    end
  end

  // Mix wide random words, small values near zero, a tiny pool for equal
  // values, and the two extremes.
  function automatic logic [31:0] pick_value();
    logic [31:0] pool[4];
    pool = '{32'd7, 32'hFFFF_FFF9, 32'd0, 32'd1000};
    case ($urandom_range(0, 7))
      0, 1, 2: return $urandom;
      3, 4:    return $urandom_range(0, 40) - 20;
      5:       return pool[$urandom_range(0, 3)];
      6:       return VAL_MAX - $urandom_range(0, 3);
      default: return VAL_MIN + $urandom_range(0, 3);
    endcase
  endfunction

  // Present one element and hold it until the handshake completes. Valid stays
  // high across back-to-back transactions; a gap drops it first.
  task automatic send_item(input logic [31:0] value, input logic last);
    if (!quiet && !calm_set && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(value, last);
    items_sent++;
  endtask

  // One set of random content; the final element raises tlast.
  task automatic send_set(input int unsigned len);
    calm_set = ($urandom_range(0, 3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_item(pick_value(), i == len - 1);
    end
    calm_set = 1'b0;
  endtask

  initial begin
    int unsigned len;
    int unsigned sel;
    sb         = new(DEPTH);
    items_sent = 0;
    quiet      = 1'b0;
    calm_set   = 1'b0;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // single-element sets at both extremes
    send_item(VAL_MAX, 1'b1);
    send_item(VAL_MIN, 1'b1);
    // reverse order across the sign boundary: worst case, every pass swaps
    send_item(VAL_MAX, 1'b0);
    send_item(32'd1, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(VAL_MIN, 1'b1);
    // already ascending: first pass makes no swap, sort exits early
    send_item(32'hFFFF_FFFD, 1'b0);
    send_item(32'hFFFF_FFFE, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'd0, 1'b0);
    send_item(32'd7, 1'b1);
    // equal values must never trade places
    send_item(32'd5, 1'b0);
    send_item(32'd5, 1'b0);
    send_item(32'hFFFF_FFFB, 1'b0);
    send_item(32'd5, 1'b1);
    // alternating bit patterns, then a two-element swap
    send_item(32'h5555_5555, 1'b0);
    send_item(32'hAAAA_AAAA, 1'b0);
    send_item(32'd0, 1'b1);
    send_item(32'd1, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b1);

    // exactly full store, then a set whose tail, final element included, is dropped
    send_set(DEPTH);
    send_set(DEPTH + 3);

    // random sets: mostly short, some long, a few at or past the store depth
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
      sel = $urandom_range(0, 9);
      if (sel <= 5)      len = $urandom_range(1, 6);
      else if (sel <= 7) len = $urandom_range(7, 20);
      else if (sel == 8) len = $urandom_range(21, DEPTH - 1);
      else               len = $urandom_range(DEPTH, DEPTH + 8);
      send_set(len);
    end
    quiet = 1'b1;
    in_tvalid <= 1'b0;

    // drain outstanding results, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (2 * DEPTH + 16) @(posedge clk);
    if (sb.errors == 0) begin
      $display("bubble_sort_early_exit_top_test: PASS");
    end else begin
      $display("bubble_sort_early_exit_top_test: FAIL");
    end
    $finish;
  end

endmodule
